// ----- hw/rtl/fdt_pkg.sv -----
// ----------------------------------------------------------------------------
// fdt_pkg: shared constants for the Q16.16 to decimal text formatter
// Digit counts, fraction scale, divide-by-ten reciprocal and ASCII codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdt_pkg;

  // Digit layout of the working store
  localparam int unsigned IntDigits  = 5;
  localparam int unsigned FracDigits = 6;
  localparam int unsigned StoreDepth = IntDigits + FracDigits;

  // Width of the operand fed to the shared divide-by-ten unit
  localparam int unsigned OpW = 20;

  // Fraction scale: six decimal places
  localparam logic [19:0] FracScale = 20'd1000000;

  // ceil(2^23 / 10); exact quotient for every operand below 2^22
  localparam logic [19:0] Recip10     = 20'd838861;
  localparam int unsigned Recip10Shift = 23;

  // ASCII codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharDot   = 8'h2e;

endpackage

// ----- hw/rtl/fixed_16_16_to_decimal_text.sv -----
// Flow: the fraction is scaled, then the integer and fraction digits are
//   extracted on one shared divide-by-ten unit, then one character per cycle
//   is issued while the output is not stalled. A new word is taken only once
//   the last character of the previous word has been issued.
// Reset: rst_ni clears the sequencer and output valid; the digit store is
//   not cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
// fixed_16_16_to_decimal_text: signed Q16.16 word to ASCII decimal text
// Sequencer around a shared divide-by-ten unit and an 11-entry digit store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_16_16_to_decimal_text import fdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] fixed_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScale,
    StInt,
    StFrac,
    StEmit
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [14:0] int_q, int_d;
  logic [19:0] frac_q, frac_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  sig_q, sig_d;
  logic [3:0]  pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;

  logic [3:0]  digit_store [StoreDepth];
  logic [3:0]  rd_digit_q;

  logic [OpW-1:0] div_op;
  logic [OpW-1:0] div_quot;
  logic [3:0]     div_rem;
  logic [35:0]    frac_prod;
  logic           wr_en;
  logic [3:0]     wr_idx;

  logic [3:0]  k;
  logic [3:0]  k_rd;
  logic [3:0]  int_idx;
  logic [3:0]  frac_idx;
  logic [3:0]  rd_idx;
  logic        in_int;
  logic        emit_go;

  // Shared divide-by-ten unit, fed from the field being worked on
  assign div_op = (state_q == StInt) ? {{(OpW-15){1'b0}}, int_q} : frac_q;

  fdt_div10 u_div10 (
    .operand_i   (div_op),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Six-place fraction, truncated
  assign frac_prod = {20'd0, mag_q[15:0]} * {16'd0, FracScale};

  // Store write port: integer digits from index 0 up, fraction digits from the top index down, low digit first
  assign wr_en  = (state_q == StInt) || (state_q == StFrac);
  assign wr_idx = (state_q == StInt) ? {1'b0, cnt_q}
                                     : 4'(StoreDepth - 1) - {1'b0, cnt_q};

  // Store: write port, and registered read of the digit for the next position
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_store[wr_idx] <= div_rem;
    end
    rd_digit_q <= digit_store[rd_idx];
  end

  // Store address for the position that is current after this edge
  assign k_rd     = pos_d - {3'd0, neg_q};
  assign in_int   = k_rd < {1'b0, sig_q};
  assign int_idx  = {1'b0, sig_q} - 4'd1 - k_rd;
  assign frac_idx = k_rd + 4'(IntDigits - 1) - {1'b0, sig_q};
  assign rd_idx   = in_int ? int_idx : frac_idx;

  // Character selection for the current text position
  assign k       = pos_q - {3'd0, neg_q};
  assign emit_go = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    int_d       = int_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    sig_d       = sig_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          neg_d   = fixed_value_i[31];
          mag_d   = fixed_value_i[31] ? (32'd0 - fixed_value_i) : fixed_value_i;
          state_d = StScale;
        end
      end
      StScale: begin
        int_d   = mag_q[30:16];
        frac_d  = frac_prod[35:16];
        cnt_d   = 3'd0;
        sig_d   = 3'd1;
        state_d = StInt;
      end
      StInt: begin
        int_d = div_quot[14:0];
        if ((div_rem != 4'd0) && (cnt_q != 3'd0)) begin
          sig_d = cnt_q + 3'd1;
        end
        if (cnt_q == 3'(IntDigits - 1)) begin
          cnt_d   = 3'd0;
          state_d = StFrac;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      StFrac: begin
        frac_d = div_quot;
        if (cnt_q == 3'(FracDigits - 1)) begin
          pos_d   = 4'd0;
          state_d = StEmit;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      StEmit: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          if (neg_q && (pos_q == 4'd0)) begin
            char_d = CharMinus;
          end else if (k == {1'b0, sig_q}) begin
            char_d = CharDot;
          end else begin
            char_d = CharZero | {4'd0, rd_digit_q};
          end
          last_d = (k == ({1'b0, sig_q} + 4'(FracDigits)));
          pos_d  = pos_q + 4'd1;
          if (last_d) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      cnt_q       <= '0;
      sig_q       <= 3'd1;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      int_q       <= int_d;
      frac_q      <= frac_d;
      cnt_q       <= cnt_d;
      sig_q       <= sig_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

// ----- hw/rtl/fdt_div10.sv -----
// ----------------------------------------------------------------------------
// fdt_div10: shared divide-by-ten unit
// Quotient by reciprocal multiply, remainder by shift-add and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdt_div10 import fdt_pkg::*; (
  input  logic [OpW-1:0] operand_i,
  output logic [OpW-1:0] quotient_o,
  output logic [3:0]     remainder_o
);

  logic [2*OpW-1:0] prod;
  logic [OpW-1:0]   quot;
  logic [OpW-1:0]   times_ten;
  logic [OpW-1:0]   diff;

  // q = floor(x * ceil(2^23/10) / 2^23); the top bits of the product hold it
  assign prod = operand_i * Recip10;
  assign quot = {{(Recip10Shift - OpW){1'b0}}, prod[2*OpW-1:Recip10Shift]};

  // r = x - 10q, always below ten
  assign times_ten = (quot << 3) + (quot << 1);
  assign diff      = operand_i - times_ten;

  assign quotient_o  = quot;
  assign remainder_o = diff[3:0];

endmodule

// ----- tb/sv/tb_fixed_16_16_to_decimal_text.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_16_16_to_decimal_text: self-checking bench for the Q16.16 formatter
// A directed table covers the extremes and the sign and zero corners. Random
// words follow, with random gaps and stalls on both channels. Each text
// character leaving the block is checked against hand-written text or an in-bench formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_16_16_to_decimal_text import fdt_pkg::*;;

  localparam int unsigned NumDirected = 18;
  localparam int unsigned NumRandom   = 410;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] fixed_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  char_code_o;
  logic        last_char_o;

  // characters still owed by the block, oldest first
  text_char_t  owed_chars[$];
  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned negative_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned numbers_done  = 0;
  bit          quiet         = 1'b0;

  // directed words; an empty text means the formatter supplies the answer
  logic [31:0] dir_value [NumDirected] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001,
    32'h0000_0001, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000,
    32'h0000_8000, 32'h0009_ffff, 32'h0063_0000, 32'h0064_0000,
    32'h03e7_0000, 32'h270f_0000, 32'h2710_0000, 32'h5555_aaaa,
    32'haaaa_5555, 32'h0000_ffff
  };
  string dir_text [NumDirected] = '{
    "0.000000", "-0.000000", "32767.999984", "-32767.999984",
    "0.000015", "-0.000015", "1.000000", "-1.000000",
    "0.500000", "", "", "",
    "", "", "", "",
    "", "0.999984"
  };

  fixed_16_16_to_decimal_text DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .fixed_value_i(fixed_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Formatter: signed Q16.16 word to its decimal characters, appended to the
  // owed list. Fraction is truncated to six digits with leading zeros kept.
  function automatic void format_q16_16(input logic [31:0] word);
    logic        neg;
    logic [31:0] mag;
    logic [14:0] whole;
    logic [47:0] scaled;
    logic [19:0] frac6;
    logic [3:0]  int_dig [IntDigits];
    logic [3:0]  frac_dig [FracDigits];
    int          sig;
    int          i;
    text_char_t  c;
    neg    = word[31];
    mag    = neg ? (32'd0 - word) : word;
    whole  = mag[30:16];
    scaled = {32'd0, mag[15:0]} * {28'd0, FracScale};
    frac6  = scaled[35:16];
    for (i = 0; i < IntDigits; i++) begin
      int_dig[i] = 4'(whole % 10);
      whole      = whole / 10;
    end
    for (i = FracDigits - 1; i >= 0; i--) begin
      frac_dig[i] = 4'(frac6 % 10);
      frac6       = frac6 / 10;
    end
    sig = 1;
    for (i = IntDigits - 1; i > 0; i--) begin
      if (int_dig[i] != 0) begin
        sig = i + 1;
        break;
      end
    end
    if (neg) begin
      owed_chars.push_back('{CharMinus, 1'b0});
    end
    for (i = sig - 1; i >= 0; i--) begin
      owed_chars.push_back('{CharZero + 8'(int_dig[i]), 1'b0});
    end
    owed_chars.push_back('{CharDot, 1'b0});
    for (i = 0; i < FracDigits; i++) begin
      c.code = CharZero + 8'(frac_dig[i]);
      c.last = (i == FracDigits - 1);
      owed_chars.push_back(c);
    end
  endfunction

  // hand-written text, last character flagged
  function automatic void owe_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      owed_chars.push_back('{8'(s[i]), (i == s.len() - 1)});
    end
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // random word: full range, bounded integer part, tiny fractions, corners
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          mode;
    int          lim;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      w = $urandom();
    end else if (mode < 8) begin
      case ($urandom_range(0, 4))
        0:       lim = 9;
        1:       lim = 99;
        2:       lim = 999;
        3:       lim = 9999;
        default: lim = 32767;
      endcase
      w = {1'b0, 15'($urandom_range(0, lim)), 16'($urandom())};
    end else if (mode == 8) begin
      w = $urandom_range(0, 1) ? 32'($urandom_range(0, 20))
                               : 32'(16'hffff - $urandom_range(0, 20));
    end else begin
      case ($urandom_range(0, 5))
        0:       w = 32'h8000_0000;
        1:       w = 32'h7fff_ffff;
        2:       w = 32'h0000_0000;
        3:       w = 32'h270f_ffff;
        4:       w = 32'h2710_0000;
        default: w = 32'h0009_0000;
      endcase
      return w;
    end
    if (mode >= 4 && $urandom_range(0, 1)) begin
      w = 32'd0 - w;
    end
    return w;
  endfunction

  // offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [31:0] word, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    fixed_value_i = word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (text.len() > 0) begin
      owe_text(text);
    end else begin
      format_q16_16(word);
    end
    words_sent++;
    if (word[31]) begin
      negative_sent++;
    end
  endtask

  // hold the input back until every owed character has come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (owed_chars.size() != 0) @(posedge clk_i);
  endtask

  // output side: random stalls, none while quiet
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // check each character word against the oldest owed one
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char 0x%02h last=%0b, nothing owed",
                 $time, char_code_o, last_char_o);
      end else begin
        want = owed_chars.pop_front();
        chars_checked++;
        if (want.last) begin
          numbers_done++;
        end
        if (char_code_o !== want.code) begin
          mismatches++;
          $display("%0t: char_code expected 0x%02h actual 0x%02h",
                   $time, want.code, char_code_o);
        end
        if (last_char_o !== want.last) begin
          mismatches++;
          $display("%0t: last_char expected %0b actual %0b",
                   $time, want.last, last_char_o);
        end
      end
    end
  end

  // main sequence
  initial begin
    int i;
    int tail;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    fixed_value_i = 32'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < NumDirected; i++) begin
      send_word(dir_value[i], dir_text[i]);
    end
    drain();

    for (i = 0; i < NumRandom; i++) begin
      quiet = (i >= 150 && i < 200);
      if (i == 100 || i == 250 || i == 350) begin
        drain();
      end
      send_word(random_word(), "");
    end
    quiet = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // let the last text come out, then watch for stray characters
    tail = 0;
    while (owed_chars.size() != 0 && tail < 20000) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (40) @(posedge clk_i);
    if (owed_chars.size() != 0) begin
      mismatches++;
      $display("%0t: %0d chars still owed at end", $time, owed_chars.size());
    end

    $display("%0d words in (%0d negative), %0d numbers and %0d chars checked",
             words_sent, negative_sent, numbers_done, chars_checked);
    $display("directed corners plus random words with gaps, stalls and drains");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("simulation failed");
    $finish;
  end

endmodule
